>>> hw/rtl/lcdf_pkg.sv
`timescale 1ns / 1ps

package lcdf_pkg;

  localparam int BYTES_PER_LINE_DEF = 16;
  localparam int LINES_DEF          = 128;

  localparam int BC_W        = 5;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [1:0] CFG_WRITE_COMMAND = 2'd0;
  localparam logic [1:0] CFG_CLEAR_COMMAND = 2'd1;
  localparam logic [1:0] CFG_VCOM_MASK     = 2'd2;
  localparam logic [1:0] CFG_INVERT_DATA   = 2'd3;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] line_index;
    logic [7:0] pixel_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       lsb_first;
    logic       end_of_transfer;
    logic       last;
  } out_item_t;

  // one queued job: clear transfer, or one pixel byte with optional header/trailer
  typedef struct packed {
    logic       clr;
    logic       hdr;
    logic       trl;
    logic [7:0] cmd;
    logic [7:0] line_num;
    logic [7:0] data;
  } job_t;

endpackage

>>> hw/rtl/lcdf_front.sv
`timescale 1ns / 1ps

module lcdf_front import lcdf_pkg::*; #(
  parameter int BYTES_PER_LINE = BYTES_PER_LINE_DEF,
  parameter int LINES          = LINES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  logic [7:0]      write_command_r;
  logic [7:0]      clear_command_r;
  logic [7:0]      vcom_mask_r;
  logic            invert_data_r;
  logic            vcom_r, vcom_nxt;
  logic [BC_W-1:0] byte_count_r, byte_count_nxt;
  logic            dropped_r, dropped_nxt;

  logic            accept;
  logic            drop_eff;
  logic [BC_W-1:0] bc_inc;
  logic [7:0]      vcom_bits;
  logic            out_of_range;

  assign in_stall     = q_full;
  assign accept       = in_valid && !q_full;
  assign vcom_bits    = vcom_r ? vcom_mask_r : 8'h00;
  assign bc_inc       = byte_count_r + BC_W'(1);
  assign out_of_range = {1'b0, in_item.line_index} >= 9'(LINES);

  always_comb begin
    q_job          = '0;
    q_push         = 1'b0;
    vcom_nxt       = vcom_r;
    byte_count_nxt = byte_count_r;
    dropped_nxt    = dropped_r;
    drop_eff       = dropped_r;
    if (accept) begin
      if (in_item.opcode == OP_CLEAR) begin
        if (byte_count_r == '0) begin
          q_push    = 1'b1;
          q_job.clr = 1'b1;
          q_job.hdr = 1'b1;
          q_job.cmd = clear_command_r | vcom_bits;
          vcom_nxt  = ~vcom_r;
        end
      end else begin
        if (byte_count_r == '0) begin
          if (out_of_range) begin
            drop_eff = 1'b1;
          end else begin
            drop_eff       = 1'b0;
            q_job.hdr      = 1'b1;
            q_job.cmd      = write_command_r | vcom_bits;
            q_job.line_num = in_item.line_index + 8'd1;
            vcom_nxt       = ~vcom_r;
          end
        end
        q_job.data = invert_data_r ? ~in_item.pixel_byte : in_item.pixel_byte;
        if (bc_inc >= BC_W'(BYTES_PER_LINE)) begin
          byte_count_nxt = '0;
          q_job.trl      = !drop_eff;
          dropped_nxt    = 1'b0;
        end else begin
          byte_count_nxt = bc_inc;
          dropped_nxt    = drop_eff;
        end
        q_push = !drop_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_command_r <= 8'd128;
      clear_command_r <= 8'd32;
      vcom_mask_r     <= 8'd64;
      invert_data_r   <= 1'b1;
      vcom_r          <= 1'b0;
      byte_count_r    <= '0;
      dropped_r       <= 1'b0;
    end else begin
      vcom_r       <= vcom_nxt;
      byte_count_r <= byte_count_nxt;
      dropped_r    <= dropped_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WRITE_COMMAND: write_command_r <= cfg_data;
          CFG_CLEAR_COMMAND: clear_command_r <= cfg_data;
          CFG_VCOM_MASK:     vcom_mask_r     <= cfg_data;
          CFG_INVERT_DATA:   invert_data_r   <= cfg_data[0];
        endcase
      end
    end
  end

endmodule

>>> hw/rtl/lcdf_queue.sv
`timescale 1ns / 1ps

module lcdf_queue import lcdf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full       = count_r == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/lcdf_back.sv
`timescale 1ns / 1ps

module lcdf_back import lcdf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  job_t      head_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  typedef enum logic [2:0] {
    ST_START,
    ST_CMD,
    ST_LINE,
    ST_DATA,
    ST_TR0,
    ST_TR1
  } step_t;

  step_t     step_r;
  step_t     cur_step;
  step_t     next_step;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t res;
  logic      load;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign load      = head_valid && (!out_valid_r || !out_stall);
  assign pop       = load && res.last;

  always_comb begin
    if (step_r == ST_START) begin
      cur_step = head_job.hdr ? ST_CMD : ST_DATA;
    end else begin
      cur_step = step_r;
    end
  end

  always_comb begin
    res       = '0;
    next_step = ST_START;
    unique case (cur_step)
      ST_CMD: begin
        res.out_byte = head_job.cmd;
        next_step    = ST_LINE;
      end
      ST_LINE: begin
        res.lsb_first = 1'b1;
        if (head_job.clr) begin
          res.end_of_transfer = 1'b1;
          res.last            = 1'b1;
        end else begin
          res.out_byte = head_job.line_num;
          next_step    = ST_DATA;
        end
      end
      ST_DATA: begin
        res.out_byte = head_job.data;
        res.last     = !head_job.trl;
        next_step    = head_job.trl ? ST_TR0 : ST_START;
      end
      ST_TR0: begin
        next_step = ST_TR1;
      end
      ST_TR1: begin
        res.end_of_transfer = 1'b1;
        res.last            = 1'b1;
      end
      default: begin
        res.last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_START;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        out_item_r  <= res;
        step_r      <= res.last ? ST_START : next_step;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/memory_lcd_line_framer_unit.sv
`timescale 1ns / 1ps

// Memory LCD line framer: pixel bytes in, serial-link bytes out, one result byte per
// cycle unless stalled. The front stage takes one item per cycle while its 4-entry
// job queue has room; the back stage expands each job through the output register,
// one byte per cycle when not stalled. A middle pixel byte yields one output byte,
// the first byte of a line three (command, line number, data), the last byte three
// (data, two trailers), a clear two (command, trailer), so a line of BYTES_PER_LINE
// bytes gives BYTES_PER_LINE + 4. Dropped lines and ignored clears produce nothing.
module memory_lcd_line_framer_unit import lcdf_pkg::*; #(
  parameter int BYTES_PER_LINE = BYTES_PER_LINE_DEF,
  parameter int LINES          = LINES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic q_full;
  logic q_push;
  job_t q_job;
  logic q_pop;
  logic head_valid;
  job_t head_job;

  lcdf_front #(
    .BYTES_PER_LINE(BYTES_PER_LINE),
    .LINES         (LINES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  lcdf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_job),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(head_valid),
    .head_job  (head_job)
  );

  lcdf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_job  (head_job),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job queue overflow");

  a_eot_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.end_of_transfer |-> out_item.last)
    else $error("chip select released before last result of an item");

  a_line_num_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.lsb_first && !out_item.last |-> out_item.out_byte != 8'd0)
    else $error("line number byte is zero");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> head_valid)
    else $error("pop from empty job queue");
`endif

endmodule
